/* rtl/kstc_pkg.sv */
// Shared types, constants and helper functions for the keyed six-bit text codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package kstc_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W      = 5;

  localparam logic [7:0]  TEXT_BIAS       = 8'h20;
  localparam logic [7:0]  TEXT_UNBIAS     = 8'he0;
  localparam logic        RST_DIRECTION   = 1'b0;
  localparam logic        RST_KEY_ENABLE  = 1'b1;
  localparam logic [31:0] RST_KEY_LOW     = 32'h6E69_5479;
  localparam logic [31:0] RST_KEY_HIGH    = 32'h3038_2E31;
  localparam logic [3:0]  RST_KEY_LENGTH  = 4'd8;

  typedef enum logic [2:0] {
    REG_DIRECTION  = 3'd0,
    REG_KEY_ENABLE = 3'd1,
    REG_KEY_LOW    = 3'd2,
    REG_KEY_HIGH   = 3'd3,
    REG_KEY_LENGTH = 3'd4
  } reg_idx_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic        direction;
    logic        key_enable;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
  } kstc_cfg_t;

  typedef struct packed {
    logic [1:0] group_position;
    logic [5:0] composite_bits;
    logic [2:0] key_position;
  } kstc_state_t;

  typedef struct packed {
    logic       we;
    logic [1:0] idx;
  } pend_wr_t;

  function automatic logic [7:0] key_byte(input logic [63:0] bytes, input logic [2:0] idx);
    return bytes[8*idx +: 8];
  endfunction

  function automatic logic [2:0] next_idx(input logic [2:0] idx, input logic [3:0] len);
    logic [3:0] inc;
    inc = {1'b0, idx} + 4'd1;
    return (inc >= len) ? 3'd0 : inc[2:0];
  endfunction

  // add with end-around carry: sums of 256 or more drop by 255
  function automatic logic [7:0] key_add(input logic [7:0] b, input logic [7:0] k);
    logic [8:0] s;
    s = {1'b0, b} + {1'b0, k};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

  function automatic logic [7:0] key_sub(input logic [7:0] v, input logic [7:0] k);
    return (v > k) ? (v - k) : (v - k - 8'd1);
  endfunction

endpackage

`default_nettype wire

/* rtl/keyed_six_bit_text_codec.sv */
// Top level of the keyed six-bit text codec: APB registers, input stage, state.
// Depends on kstc_pkg, kstc_xform and kstc_fifo.
`default_nettype none

// Converts bytes to uuencode-style text (direction 0) or text back to bytes
// (direction 1), with an optional repeating key of up to KEY_BYTES bytes.
// An accepted item is registered, transformed in the next cycle and its 0 to 3
// results land in an 8-entry result queue, so one item per cycle is taken while
// the queue has room; output is one result per cycle while out_stall is low, so
// sustained input rate is set by the result count (encode: 4 results per 3
// bytes). Items are stalled while the queue could not hold the results of the
// item in flight plus a new one. The user must write registers only while
// the block is idle; the block itself does not enforce this.

module keyed_six_bit_text_codec
  import kstc_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  kstc_cfg_t        cfg_r;
  kstc_state_t      st_r, st_nxt;
  logic [2:0][7:0]  pend_r;
  in_item_t         in_r;
  logic             v_r;
  logic             accept, cfg_wr;
  reg_idx_t         reg_idx;
  out_item_t [2:0]  res;
  logic [1:0]       res_cnt;
  pend_wr_t         pend_wr;
  logic [CNT_W-1:0] count;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign accept  = in_valid && !in_stall;
  assign in_stall = (count + (v_r ? CNT_W'(MAX_RESULTS) : CNT_W'(0)))
                    > CNT_W'(FIFO_DEPTH - MAX_RESULTS);

  always_comb begin
    unique case (reg_idx)
      REG_DIRECTION:  prdata = {31'b0, cfg_r.direction};
      REG_KEY_ENABLE: prdata = {31'b0, cfg_r.key_enable};
      REG_KEY_LOW:    prdata = cfg_r.key_bytes[31:0];
      REG_KEY_HIGH:   prdata = cfg_r.key_bytes[63:32];
      REG_KEY_LENGTH: prdata = {28'b0, cfg_r.key_length};
      default:        prdata = '0;
    endcase
  end

  kstc_xform #(.KEY_BYTES(KEY_BYTES)) u_xform (
    .cfg     (cfg_r),
    .st      (st_r),
    .pend    (pend_r),
    .item    (in_r),
    .res     (res),
    .res_cnt (res_cnt),
    .st_nxt  (st_nxt),
    .pend_wr (pend_wr)
  );

  kstc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (v_r ? res_cnt : 2'd0),
    .push_data (res),
    .pop       (out_valid && !out_stall),
    .count     (count),
    .head      (out_item)
  );

  assign out_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
    if (v_r && pend_wr.we) begin
      pend_r[pend_wr.idx] <= in_r.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r                  <= 1'b0;
      st_r                 <= '0;
      cfg_r.direction      <= RST_DIRECTION;
      cfg_r.key_enable     <= RST_KEY_ENABLE;
      cfg_r.key_bytes      <= {RST_KEY_HIGH, RST_KEY_LOW};
      cfg_r.key_length     <= RST_KEY_LENGTH;
    end else begin
      v_r <= accept;
      if (cfg_wr && reg_idx == REG_DIRECTION) begin
        st_r <= '0;
      end else if (v_r) begin
        st_r <= st_nxt;
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_DIRECTION:  cfg_r.direction         <= pwdata[0];
          REG_KEY_ENABLE: cfg_r.key_enable        <= pwdata[0];
          REG_KEY_LOW:    cfg_r.key_bytes[31:0]   <= pwdata;
          REG_KEY_HIGH:   cfg_r.key_bytes[63:32]  <= pwdata;
          REG_KEY_LENGTH: cfg_r.key_length        <= pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/kstc_xform.sv */
// Per-item datapath: key add/subtract, six-bit split and group assembly.
// Purely combinational; depends on kstc_pkg.
`default_nettype none

module kstc_xform
  import kstc_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  kstc_cfg_t             cfg,
  input  kstc_state_t           st,
  input  logic [2:0][7:0]       pend,
  input  in_item_t              item,
  output out_item_t [2:0]       res,
  output logic [1:0]            res_cnt,
  output kstc_state_t           st_nxt,
  output pend_wr_t              pend_wr
);

  logic [3:0]      len;
  logic [2:0]      idx0, idx1, idx2, idx3;
  logic [7:0]      b_enc, k0;
  logic [1:0]      pe;
  logic [5:0]      comp_or, comp_new;
  logic [7:0]      comp_dec;
  logic [2:0][1:0] hi;
  logic [2:0][7:0] dec_byte;
  logic [2:0]      dec_idx [3];
  logic            last;
  logic [1:0]      p;

  always_comb begin
    if (cfg.key_length == 4'd0) begin
      len = 4'd1;
    end else if (cfg.key_length > 4'(KEY_BYTES)) begin
      len = 4'(KEY_BYTES);
    end else begin
      len = cfg.key_length;
    end
  end

  assign idx0 = ({1'b0, st.key_position} >= len) ? 3'd0 : st.key_position;
  assign idx1 = next_idx(idx0, len);
  assign idx2 = next_idx(idx1, len);
  assign idx3 = next_idx(idx2, len);
  assign dec_idx[0] = idx0;
  assign dec_idx[1] = idx1;
  assign dec_idx[2] = idx2;

  assign last = item.in_last;
  assign p    = st.group_position;

  // encode path
  assign k0    = key_byte(cfg.key_bytes, idx0);
  assign b_enc = cfg.key_enable ? key_add(item.data_in, k0) : item.data_in;
  assign pe    = (p > 2'd2) ? 2'd2 : p;

  always_comb begin
    unique case (pe)
      2'd0:    comp_or = {b_enc[7:6], 4'b0};
      2'd1:    comp_or = {2'b0, b_enc[7:6], 2'b0};
      default: comp_or = {4'b0, b_enc[7:6]};
    endcase
  end

  assign comp_new = st.composite_bits | comp_or;

  // decode path
  assign comp_dec = item.data_in + TEXT_UNBIAS;
  assign hi[0] = comp_dec[5:4];
  assign hi[1] = comp_dec[3:2];
  assign hi[2] = comp_dec[1:0];

  for (genvar i = 0; i < MAX_RESULTS; i++) begin : g_dec
    logic [7:0] v, k;
    assign v = (pend[i] + TEXT_UNBIAS) | {hi[i], 6'b0};
    assign k = key_byte(cfg.key_bytes, dec_idx[i]);
    assign dec_byte[i] = cfg.key_enable ? key_sub(v, k) : v;
  end

  always_comb begin
    res          = '0;
    res_cnt      = 2'd0;
    st_nxt       = st;
    pend_wr.we   = 1'b0;
    pend_wr.idx  = p;
    if (cfg.direction == DIR_ENCODE) begin
      res[0].data_out    = {2'b0, b_enc[5:0]} + TEXT_BIAS;
      st_nxt.key_position = idx1;
      if (pe == 2'd2 || last) begin
        res[1].data_out      = {2'b0, comp_new} + TEXT_BIAS;
        res_cnt              = 2'd2;
        st_nxt.composite_bits = '0;
        st_nxt.group_position = '0;
      end else begin
        res_cnt               = 2'd1;
        st_nxt.composite_bits = comp_new;
        st_nxt.group_position = pe + 2'd1;
      end
    end else if (p != 2'd3 && !last) begin
      pend_wr.we            = 1'b1;
      st_nxt.group_position = p + 2'd1;
    end else begin
      res[0].data_out = dec_byte[0];
      res[1].data_out = dec_byte[1];
      res[2].data_out = dec_byte[2];
      res_cnt         = p;
      unique case (p)
        2'd0:    st_nxt.key_position = st.key_position;
        2'd1:    st_nxt.key_position = idx1;
        2'd2:    st_nxt.key_position = idx2;
        default: st_nxt.key_position = idx3;
      endcase
      st_nxt.group_position = '0;
      st_nxt.composite_bits = '0;
    end
    if (last) begin
      if (res_cnt != 2'd0) begin
        res[res_cnt - 2'd1].out_last = 1'b1;
      end
      st_nxt = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/kstc_fifo.sv */
// Result queue: takes up to three items per cycle, hands out one per cycle while popped.
// Depends on kstc_pkg.
`default_nettype none

module kstc_fifo
  import kstc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  out_item_t [2:0]  push_data,
  input  logic             pop,
  output logic [CNT_W-1:0] count,
  output out_item_t        head
);

  out_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push_cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (2'(j) < push_cnt) begin
        mem[wr_ptr_r + PTR_W'(j)] <= push_data[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign count = count_r;
  assign head  = mem[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/kstc_checker.sv */
// Port-level checks for keyed_six_bit_text_codec, bound to the top level.
// Depends on kstc_pkg.
`default_nettype none

module kstc_checker
  import kstc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_item,
  input logic              psel,
  input logic              pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty or input stalled after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result queue is empty");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> pready)
    else $error("register port inserted a wait state");

endmodule

bind keyed_six_bit_text_codec kstc_checker u_kstc_checker (.*);

`default_nettype wire

/* sim/keyed_six_bit_text_codec_tb.sv */
// Self-checking testbench for keyed_six_bit_text_codec: directed and random byte/text
// items in both directions with random idling, checked against a built-in predictor.
// Depends on kstc_pkg and the RTL of the codec.
`default_nettype none

module keyed_six_bit_text_codec_tb
  import kstc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  class text_codec_scoreboard;
    dir_t        dir;
    logic        key_en;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [1:0]  grp_pos;
    logic [5:0]  comp_bits;
    logic [7:0]  held_chars[3];
    logic [2:0]  key_pos;
    out_item_t   coded_q[$];
    int          errors;

    function new();
      dir       = DIR_ENCODE;
      key_en    = RST_KEY_ENABLE;
      key_bytes = {RST_KEY_HIGH, RST_KEY_LOW};
      key_len   = RST_KEY_LENGTH;
      clear_group();
      errors    = 0;
    endfunction

    function void clear_group();
      grp_pos   = '0;
      comp_bits = '0;
      key_pos   = '0;
    endfunction

    function void set_register(int idx, logic [31:0] val);
      case (idx)
        REG_DIRECTION: begin
          dir = dir_t'(val[0]);
          clear_group();
        end
        REG_KEY_ENABLE: key_en = val[0];
        REG_KEY_LOW:    key_bytes[31:0] = val;
        REG_KEY_HIGH:   key_bytes[63:32] = val;
        REG_KEY_LENGTH: key_len = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] next_key_byte();
      logic [3:0] len;
      logic [3:0] idx;
      logic [7:0] k;
      len = key_len;
      if (len == 4'd0) len = 4'd1;
      if (len > 4'd8) len = 4'd8;
      idx = {1'b0, key_pos};
      if (idx >= len) idx = 4'd0;
      k = key_bytes[8*idx +: 8];
      idx = idx + 4'd1;
      if (idx >= len) idx = 4'd0;
      key_pos = idx[2:0];
      return k;
    endfunction

    function void predict_from_item(in_item_t it);
      logic [7:0] b;
      logic [7:0] k;
      logic [8:0] s;
      logic [1:0] p;
      logic [7:0] comp;
      logic [7:0] hi;
      logic [7:0] v;
      int         sh;
      b = it.data_in;
      p = grp_pos;
      if (dir == DIR_ENCODE) begin
        k = next_key_byte();
        if (key_en) begin
          s = {1'b0, b} + {1'b0, k};
          if (s >= 9'd256) s = s - 9'd255;
          b = s[7:0];
        end
        if (p > 2'd2) p = 2'd2;
        sh = 2 + 2 * p;
        coded_q.push_back('{data_out: (b & 8'h3f) + TEXT_BIAS, out_last: 1'b0});
        comp = {2'b00, comp_bits} | ((b & 8'hc0) >> sh);
        comp_bits = comp[5:0];
        if (p >= 2'd2 || it.in_last) begin
          coded_q.push_back('{data_out: {2'b00, comp_bits} + TEXT_BIAS,
                              out_last: it.in_last});
          comp_bits = '0;
          grp_pos = '0;
        end else begin
          grp_pos = p + 2'd1;
        end
        if (it.in_last) clear_group();
        return;
      end
      if (p < 2'd3 && !it.in_last) begin
        held_chars[p] = b;
        grp_pos = p + 2'd1;
        return;
      end
      comp = b + TEXT_UNBIAS;
      for (int i = 0; i < p; i++) begin
        sh = 2 + 2 * i;
        hi = (comp & (8'hc0 >> sh)) << sh;
        v = (held_chars[i] + TEXT_UNBIAS) | hi;
        k = next_key_byte();
        if (key_en) v = (v > k) ? v - k : v + 8'hff - k;
        coded_q.push_back('{data_out: v, out_last: it.in_last && (i == p - 1)});
      end
      grp_pos = '0;
      comp_bits = '0;
      if (it.in_last) clear_group();
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t mismatch %s: got %02h expected %02h", $time, what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (coded_q.size() == 0) begin
        report_mismatch("unexpected result", got.data_out, 8'h00);
        return;
      end
      want = coded_q.pop_front();
      if (got.data_out !== want.data_out)
        report_mismatch("data_out", got.data_out, want.data_out);
      if (got.out_last !== want.out_last)
        report_mismatch("out_last", {7'd0, got.out_last}, {7'd0, want.out_last});
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  text_codec_scoreboard sb = new();
  int gap_pct   = 0;
  int stall_pct = 0;

  keyed_six_bit_text_codec DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.predict_from_item(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task write_reg(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task send_item(input logic [7:0] data, input logic last);
    in_item_t it;
    it.data_in = data;
    it.in_last = last;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, wait out every expected result and the pipeline tail
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.coded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task send_message(input int len, input bit text_like);
    logic [7:0] d;
    for (int j = 0; j < len; j++) begin
      if (text_like && $urandom_range(0, 9) < 8) d = 8'($urandom_range(8'h20, 8'h5f));
      else d = 8'($urandom_range(0, 255));
      send_item(d, j == len - 1);
    end
  endtask

  initial begin
    #2_000_000;
    $display("keyed_six_bit_text_codec_tb: FAIL");
    $finish;
  end

  initial begin
    logic [3:0] lengths[8];
    int         sent;
    int         len;
    lengths = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd3, 4'd5, 4'd2};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    out_stall <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode with the reset key, full group ending the message
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    settle();
    write_reg(REG_KEY_LOW, 32'hff01_00ff);
    write_reg(REG_KEY_LENGTH, 32'd4);
    send_item(8'h00, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    settle();
    // open message, then shorten the key under a stale key position
    write_reg(REG_KEY_LENGTH, 32'd8);
    for (int j = 0; j < 5; j++) send_item(8'($urandom_range(0, 255)), 1'b0);
    settle();
    write_reg(REG_KEY_LENGTH, 32'd3);
    send_item(8'h5a, 1'b1);
    settle();
    write_reg(5, $urandom);
    write_reg(7, $urandom);

    // decode: key equal, below and above the byte; short and dangling groups
    write_reg(REG_KEY_LOW, 32'h0102_80ff);
    write_reg(REG_KEY_HIGH, 32'h0000_7f40);
    write_reg(REG_KEY_LENGTH, 32'd8);
    write_reg(REG_DIRECTION, DIR_DECODE);
    send_item(8'h20, 1'b0);
    send_item(8'ha0, 1'b0);
    send_item(8'h21, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5f, 1'b0);
    send_item(8'h1f, 1'b1);
    send_item(8'h41, 1'b0);
    send_item(8'h3f, 1'b1);
    send_item(8'h30, 1'b0);
    send_item(8'h31, 1'b0);
    send_item(8'h5f, 1'b1);
    send_item(8'h55, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_KEY_ENABLE, (ph == 2 || ph == 5) ? 32'd0 : 32'd1);
      write_reg(REG_KEY_LOW, (ph == 0) ? 32'hffff_ffff : (ph == 1) ? 32'd0 : $urandom);
      write_reg(REG_KEY_HIGH, (ph == 0) ? 32'hffff_ffff : (ph == 3) ? 32'd0 : $urandom);
      write_reg(REG_KEY_LENGTH, {28'd0, lengths[ph]});
      write_reg(REG_DIRECTION, (ph & 1) ? DIR_DECODE : DIR_ENCODE);
      case ((ph >> 1) & 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 84; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 84; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      sent = 0;
      while (sent < 24) begin
        if (ph & 1) len = 4 * $urandom_range(0, 3) + $urandom_range(1, 4);
        else len = $urandom_range(1, 12);
        send_message(len, (ph & 1) != 0);
        sent += len;
      end
      settle();
      gap_pct = 0;
      stall_pct = 0;
    end

    if (sb.errors == 0) begin
      $display("keyed_six_bit_text_codec_tb: PASS");
    end else begin
      $display("keyed_six_bit_text_codec_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
